FILE: design/orbb_pkg.sv
// Shared types and constants for the overwriting byte ring buffer.
// Holds transaction field layouts, operation codes and controller/datapath types.
// No dependencies.
`timescale 1ns / 1ps

package orbb_pkg;

   localparam int KIND_W     = 3;
   localparam int VALUE_W    = 8;
   localparam int OFFSET_W   = 9;
   localparam int ECOUNT_W   = 10;
   localparam int DATA_W     = 8;
   localparam int FILL_W     = 10;

   localparam int VALUE_LSB  = 0;
   localparam int OFFSET_LSB = VALUE_LSB + VALUE_W;
   localparam int ECOUNT_LSB = OFFSET_LSB + OFFSET_W;
   localparam int CLEAR_BIT  = ECOUNT_LSB + ECOUNT_W;
   localparam int REQ_TDATA_W = 32;

   localparam int RDATA_LSB  = 0;
   localparam int OK_BIT     = RDATA_LSB + DATA_W;
   localparam int FILL_LSB   = OK_BIT + 1;
   localparam int EMPTY_BIT  = FILL_LSB + FILL_W;
   localparam int FULL_BIT   = EMPTY_BIT + 1;
   localparam int RSP_PAD_W  = 3;
   localparam int RSP_TDATA_W = FULL_BIT + 1 + RSP_PAD_W;

   localparam logic [VALUE_W-1:0] POP_MARK = 8'hFE;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 3'd0,
      KIND_POP   = 3'd1,
      KIND_PEEK  = 3'd2,
      KIND_ERASE = 3'd3,
      KIND_FIND  = 3'd4,
      KIND_FLUSH = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PEEK_WRAP,
      ST_PEEK_READ,
      ST_ERASE,
      ST_FIND_READ,
      ST_FIND_CMP,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_PEEK_WRAP,
      OP_PEEK_READ,
      OP_ERASE_STEP,
      OP_FIND_READ,
      OP_FIND_CMP,
      OP_SWEEP_STEP,
      OP_LOAD_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic occ_zero;
      logic sum_wrap;
      logic erase_ok;
      logic cnt_zero;
      logic match;
      logic walk_last;
   } dp_status_type;

endpackage

FILE: design/overwriting_byte_ring_buffer.sv
// Top level of the overwriting byte ring buffer.
// Joins orbb_ctrl and orbb_dpath; uses orbb_pkg.
`timescale 1ns / 1ps

// A byte FIFO of DEPTH entries that overwrites its oldest entry when pushed full.
// Requests arrive on the req_ stream: tuser carries the operation (push, pop, peek,
// erase, find, flush) and tdata its operands. Every request yields exactly one
// response transaction on the rsp_ stream with the returned byte, a success flag
// and the fill level, empty and full flags after the operation.
// One request is worked on at a time. Push, pop, flush without clearing, the
// unused codes and peek on an empty ring go from acceptance straight to the
// finish state. Otherwise peek passes through a wrap state, which reduces the
// read pointer plus offset by DEPTH while it is DEPTH or more (at most once when
// DEPTH is at least 512), and then a read state. Erase of N entries makes one
// storage write for each. Find reads and then compares each entry through the
// single read port. Flush with clearing zeroes every entry in turn.
// After reset the storage is zeroed one entry per cycle, and
// req_tready stays low until that pass ends. The response sits in an output
// register; while the receiver stalls, the next request is still accepted and
// worked on, and its response waits until the register frees.
module overwriting_byte_ring_buffer #(
   parameter int DEPTH = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: value[7:0], offset[16:8], erase_count[26:17],
   // clear_contents[27], zero padding.
   input  logic [orbb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: kind[2:0].
   input  logic [orbb_pkg::KIND_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: data[7:0], ok[8], fill_level[18:9], is_empty[19],
   // is_full[20], zero padding.
   output logic [orbb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import orbb_pkg::*;

   kind_type      req_kind;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign req_kind = kind_type'(req_tuser);

   orbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_kind),
      .req_clear  (req_tdata[CLEAR_BIT]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

   orbb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_kind  (req_kind),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_tdata (rsp_tdata)
   );

   // A request is never followed by another acceptance in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one still in progress");

   // The output register is only reloaded when its contents have been taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == OP_LOAD_OUT) |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten before it was taken");

   // The ring cannot be reported both empty and full.
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[EMPTY_BIT] && rsp_tdata[FULL_BIT]))
      else $error("response flags report empty and full together");

endmodule

FILE: design/orbb_ctrl.sv
// Controller state machine for the overwriting byte ring buffer.
// Sequences datapath operations per transaction; uses orbb_pkg.
`timescale 1ns / 1ps

module orbb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  orbb_pkg::kind_type     req_kind,
   input  logic                   req_clear,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output orbb_pkg::dp_cmd_type   cmd,
   input  orbb_pkg::dp_status_type status
);
   import orbb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.walk_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_PEEK:  state_in = status.occ_zero ? ST_FINISH : ST_PEEK_WRAP;
                  KIND_ERASE: state_in = ST_ERASE;
                  KIND_FIND:  state_in = ST_FIND_READ;
                  KIND_FLUSH: state_in = req_clear ? ST_SWEEP : ST_FINISH;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_PEEK_WRAP: begin
            if (!status.sum_wrap) state_in = ST_PEEK_READ;
         end
         ST_PEEK_READ: state_in = ST_FINISH;
         ST_ERASE: begin
            if (!status.erase_ok || status.cnt_zero) state_in = ST_FINISH;
         end
         ST_FIND_READ: state_in = status.cnt_zero ? ST_FINISH : ST_FIND_CMP;
         ST_FIND_CMP:  state_in = status.match ? ST_FINISH : ST_FIND_READ;
         ST_SWEEP: begin
            if (status.walk_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_CLEAR:     cmd.op = OP_SWEEP_STEP;
         ST_IDLE:      cmd.op = accept ? OP_START : OP_NONE;
         ST_PEEK_WRAP: cmd.op = OP_PEEK_WRAP;
         ST_PEEK_READ: cmd.op = OP_PEEK_READ;
         ST_ERASE: begin
            cmd.op = (status.erase_ok && !status.cnt_zero) ? OP_ERASE_STEP : OP_NONE;
         end
         ST_FIND_READ: cmd.op = status.cnt_zero ? OP_NONE : OP_FIND_READ;
         ST_FIND_CMP:  cmd.op = OP_FIND_CMP;
         ST_SWEEP:     cmd.op = OP_SWEEP_STEP;
         ST_FINISH:    cmd.op = out_free ? OP_LOAD_OUT : OP_NONE;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) rsp_tvalid_in = 1'b0;
      if (cmd.op == OP_LOAD_OUT) rsp_tvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

FILE: design/orbb_dpath.sv
// Datapath for the overwriting byte ring buffer: storage, pointers, counters.
// Executes controller operations and reports status; uses orbb_pkg.
`timescale 1ns / 1ps

module orbb_dpath #(
   parameter int DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [orbb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  orbb_pkg::kind_type             req_kind,
   input  orbb_pkg::dp_cmd_type           cmd,
   output orbb_pkg::dp_status_type        status,
   output logic [orbb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import orbb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int NW = (CW > ECOUNT_W) ? CW : ECOUNT_W;
   localparam int SW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_OCC  = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;
   logic               mem_we;
   logic [PW-1:0]      mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [PW-1:0]      mem_raddr;

   logic [PW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic [PW-1:0]      walk_ff, walk_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [SW-1:0]      sum_ff, sum_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               ok_ff, ok_in;
   logic               sel_ff, sel_in;

   logic [DATA_W-1:0]  out_data_ff, out_data_in;
   logic               out_ok_ff, out_ok_in;
   logic [FILL_W-1:0]  out_fill_ff, out_fill_in;
   logic               out_empty_ff, out_empty_in;
   logic               out_full_ff, out_full_in;

   logic [VALUE_W-1:0]    req_value;
   logic [OFFSET_W-1:0]   req_offset;
   logic [ECOUNT_W-1:0]   req_ecount;
   logic [CW+FILL_W-1:0]  occ_ext;

   assign req_value  = req_tdata[VALUE_LSB +: VALUE_W];
   assign req_offset = req_tdata[OFFSET_LSB +: OFFSET_W];
   assign req_ecount = req_tdata[ECOUNT_LSB +: ECOUNT_W];
   assign occ_ext    = {{FILL_W{1'b0}}, occ_ff};

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   assign status.occ_zero  = (occ_ff == '0);
   assign status.sum_wrap  = (sum_ff >= DEPTH_SUM);
   assign status.erase_ok  = ok_ff;
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.match     = (rdata_ff == value_ff);
   assign status.walk_last = (walk_ff == LAST_PTR);

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      occ_in    = occ_ff;
      walk_in   = walk_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      value_in  = value_ff;
      ok_in     = ok_ff;
      sel_in    = sel_ff;
      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = req_value;
      mem_re    = 1'b0;
      mem_raddr = rp_ff;
      out_data_in  = out_data_ff;
      out_ok_in    = out_ok_ff;
      out_fill_in  = out_fill_ff;
      out_empty_in = out_empty_ff;
      out_full_in  = out_full_ff;

      unique case (cmd.op)
         OP_START: begin
            ok_in    = 1'b0;
            sel_in   = 1'b0;
            value_in = req_value;
            case (req_kind)
               KIND_PUSH: begin
                  mem_we    = 1'b1;
                  mem_waddr = wp_ff;
                  mem_wdata = req_value;
                  wp_in     = next_ptr(wp_ff);
                  if (occ_ff != FULL_OCC) begin
                     occ_in = occ_ff + 1'b1;
                  end else begin
                     rp_in = next_ptr(rp_ff);
                  end
               end
               KIND_POP: begin
                  if (occ_ff != '0) begin
                     mem_re    = 1'b1;
                     mem_raddr = rp_ff;
                     mem_we    = 1'b1;
                     mem_waddr = rp_ff;
                     mem_wdata = POP_MARK;
                     rp_in     = next_ptr(rp_ff);
                     occ_in    = occ_ff - 1'b1;
                     sel_in    = 1'b1;
                  end
               end
               KIND_PEEK: begin
                  sum_in = SW'(rp_ff) + SW'(req_offset);
                  ok_in  = (occ_ff != '0);
                  sel_in = (occ_ff != '0);
               end
               KIND_ERASE: begin
                  cnt_in = NW'(req_ecount);
                  ok_in  = (NW'(req_ecount) <= NW'(occ_ff));
               end
               KIND_FIND: begin
                  cnt_in  = NW'(occ_ff);
                  walk_in = rp_ff;
               end
               KIND_FLUSH: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  occ_in  = '0;
                  walk_in = '0;
               end
               default: ;
            endcase
         end
         OP_PEEK_WRAP: begin
            if (status.sum_wrap) sum_in = sum_ff - DEPTH_SUM;
         end
         OP_PEEK_READ: begin
            mem_re    = 1'b1;
            mem_raddr = sum_ff[PW-1:0];
         end
         OP_ERASE_STEP: begin
            mem_we    = 1'b1;
            mem_waddr = rp_ff;
            mem_wdata = POP_MARK;
            rp_in     = next_ptr(rp_ff);
            occ_in    = occ_ff - 1'b1;
            cnt_in    = cnt_ff - 1'b1;
         end
         OP_FIND_READ: begin
            mem_re    = 1'b1;
            mem_raddr = walk_ff;
            walk_in   = next_ptr(walk_ff);
            cnt_in    = cnt_ff - 1'b1;
         end
         OP_FIND_CMP: begin
            if (status.match) ok_in = 1'b1;
         end
         OP_SWEEP_STEP: begin
            mem_we    = 1'b1;
            mem_waddr = walk_ff;
            mem_wdata = '0;
            walk_in   = next_ptr(walk_ff);
         end
         OP_LOAD_OUT: begin
            out_data_in  = sel_ff ? rdata_ff : '0;
            out_ok_in    = ok_ff;
            out_fill_in  = occ_ext[FILL_W-1:0];
            out_empty_in = (occ_ff == '0);
            out_full_in  = (occ_ff == FULL_OCC);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         occ_ff  <= '0;
         walk_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         occ_ff  <= occ_in;
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      value_ff     <= value_in;
      ok_ff        <= ok_in;
      sel_ff       <= sel_in;
      out_data_ff  <= out_data_in;
      out_ok_ff    <= out_ok_in;
      out_fill_ff  <= out_fill_in;
      out_empty_ff <= out_empty_in;
      out_full_ff  <= out_full_in;
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_full_ff, out_empty_ff, out_fill_ff,
                       out_ok_ff, out_data_ff};

endmodule

FILE: dv/overwriting_byte_ring_buffer_tb.sv
// Self-checking testbench for the overwriting byte ring buffer.
// Streams push, pop, peek, erase, find and flush requests and checks every response
// against an in-bench model of the ring. Depends on orbb_pkg and the top-level RTL.
`timescale 1ns / 1ps

module overwriting_byte_ring_buffer_tb;
   import orbb_pkg::*;

   localparam int RING_DEPTH = 512;
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              ok;
      logic [FILL_W-1:0] fill;
      logic              empty;
      logic              full;
   } ring_reply_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [7:0]     ring_mem [RING_DEPTH];
   int             wr_ptr;
   int             rd_ptr;
   int             ring_fill;
   ring_reply_type ring_replies_due [$];

   bit no_idle = 1'b0;
   int rsp_gap = 0;
   int replies_paced = 0;
   int fail_count = 0;
   int requests_sent = 0;
   int replies_seen = 0;

   overwriting_byte_ring_buffer #(.DEPTH(RING_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic int draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic void ring_clear();
      for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = 8'h00;
   endfunction

   function automatic logic [7:0] take_oldest();
      logic [7:0] b;
      b = 8'h00;
      if (ring_fill > 0) begin
         b = ring_mem[rd_ptr];
         ring_mem[rd_ptr] = POP_MARK;
         rd_ptr = (rd_ptr + 1) % RING_DEPTH;
         ring_fill--;
      end
      return b;
   endfunction

   function automatic ring_reply_type predict_ring_reply(input logic [KIND_W-1:0] k,
                                                         input logic [7:0] value,
                                                         input logic [8:0] offset,
                                                         input logic [9:0] ecount,
                                                         input logic clr);
      ring_reply_type r;
      r = '0;
      case (k)
         KIND_PUSH: begin
            ring_mem[wr_ptr] = value;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) ring_fill++;
            else rd_ptr = (rd_ptr + 1) % RING_DEPTH;
         end
         KIND_POP: r.data = take_oldest();
         KIND_PEEK: begin
            if (ring_fill > 0) begin
               r.data = ring_mem[(rd_ptr + offset) % RING_DEPTH];
               r.ok = 1'b1;
            end
         end
         KIND_ERASE: begin
            if (ecount <= ring_fill) begin
               repeat (ecount) void'(take_oldest());
               r.ok = 1'b1;
            end
         end
         KIND_FIND: begin
            for (int i = 0; i < ring_fill; i++) begin
               if (ring_mem[(rd_ptr + i) % RING_DEPTH] == value) begin
                  r.ok = 1'b1;
                  break;
               end
            end
         end
         KIND_FLUSH: begin
            ring_fill = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            if (clr) ring_clear();
         end
         default: ;
      endcase
      r.fill = ring_fill[FILL_W-1:0];
      r.empty = (ring_fill == 0);
      r.full = (ring_fill >= RING_DEPTH);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
                                   replies_seen, name, got, want));
   endtask

   always @(negedge clock) begin
      if (replies_seen != replies_paced) begin
         replies_paced = replies_seen;
         rsp_gap = draw_gap();
      end
      if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_replies
      ring_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (ring_replies_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with none outstanding",
                                      replies_seen));
         end else begin
            want = ring_replies_due.pop_front();
            check_field("data", rsp_tdata[RDATA_LSB +: DATA_W], want.data);
            check_field("ok", rsp_tdata[OK_BIT], want.ok);
            check_field("fill_level", rsp_tdata[FILL_LSB +: FILL_W], want.fill);
            check_field("is_empty", rsp_tdata[EMPTY_BIT], want.empty);
            check_field("is_full", rsp_tdata[FULL_BIT], want.full);
         end
      end
   end

   task automatic send_request(input logic [KIND_W-1:0] k, input logic [7:0] value,
                               input logic [8:0] offset, input logic [9:0] ecount,
                               input logic clr);
      logic [REQ_TDATA_W-1:0] word;
      int gap;
      word = '0;
      word[VALUE_LSB +: VALUE_W] = value;
      word[OFFSET_LSB +: OFFSET_W] = offset;
      word[ECOUNT_LSB +: ECOUNT_W] = ecount;
      word[CLEAR_BIT] = clr;
      gap = draw_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring_replies_due.push_back(predict_ring_reply(k, value, offset, ecount, clr));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ring_replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_ring();
      send_request(KIND_POP, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'd1, 1'b0);
      send_request(KIND_FIND, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_SPARE_A, 8'hFF, 9'h1FF, 10'h3FF, 1'b1);
      send_request(KIND_SPARE_B, 8'h00, 9'd0, 10'd0, 1'b0);
   endtask

   task automatic test_basic_ops();
      send_request(KIND_PUSH, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PUSH, 8'hFF, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PUSH, 8'hA5, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'd2, 10'd0, 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'h1FF, 10'd0, 1'b0);
      send_request(KIND_FIND, 8'hFF, 9'd0, 10'd0, 1'b0);
      send_request(KIND_FIND, 8'h5A, 9'd0, 10'd0, 1'b0);
      send_request(KIND_POP, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'h1FF, 10'd0, 1'b0);
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'h3FF, 1'b0);
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'd2, 1'b0);
      send_request(KIND_FIND, 8'hA5, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PUSH, 8'h11, 9'd0, 10'd0, 1'b0);
      send_request(KIND_FLUSH, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PUSH, 8'h22, 9'd0, 10'd0, 1'b0);
      send_request(KIND_FLUSH, 8'h00, 9'd0, 10'd0, 1'b1);
   endtask

   // Pushes past a full ring so that the oldest entries are overwritten, then
   // reads, searches and drains the wrapped contents.
   task automatic test_wrap_around();
      int extra;
      extra = $urandom_range(1, 100);
      for (int i = 0; i < RING_DEPTH + extra; i++) begin
         no_idle = (i < 200);
         send_request(KIND_PUSH, 8'($urandom), 9'd0, 10'd0, 1'b0);
      end
      no_idle = 1'b0;
      repeat (12) send_request(KIND_PEEK, 8'h00, 9'($urandom), 10'd0, 1'b0);
      repeat (4) send_request(KIND_FIND, 8'($urandom), 9'd0, 10'd0, 1'b0);
      repeat (3) send_request(KIND_FIND, ring_mem[(rd_ptr + $urandom_range(0, ring_fill - 1))
                                                  % RING_DEPTH], 9'd0, 10'd0, 1'b0);
      repeat (8) send_request(KIND_POP, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'($urandom_range(0, ring_fill)), 1'b0);
      repeat (6) send_request(KIND_PUSH, 8'($urandom), 9'd0, 10'd0, 1'b0);
      wait_drained();
      send_request(KIND_ERASE, 8'h00, 9'd0, 10'(ring_fill), 1'b0);
      send_request(KIND_PEEK, 8'h00, 9'($urandom), 10'd0, 1'b0);
      repeat (20) send_request(KIND_PUSH, 8'($urandom), 9'd0, 10'd0, 1'b0);
      send_request(KIND_FLUSH, 8'h00, 9'd0, 10'd0, 1'b0);
      send_request(KIND_PUSH, 8'($urandom), 9'd0, 10'd0, 1'b0);
      repeat (4) send_request(KIND_PEEK, 8'h00, 9'($urandom_range(1, 40)), 10'd0, 1'b0);
   endtask

   task automatic test_random_mix(input int count);
      int pick;
      logic [KIND_W-1:0] k;
      logic [7:0] v;
      logic [9:0] ec;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 40) k = KIND_PUSH;
         else if (pick < 55) k = KIND_POP;
         else if (pick < 70) k = KIND_PEEK;
         else if (pick < 80) k = KIND_ERASE;
         else if (pick < 92) k = KIND_FIND;
         else if (pick < 96) k = KIND_FLUSH;
         else k = ($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
         v = 8'($urandom);
         if (k == KIND_FIND && ring_fill > 0 && $urandom_range(0, 1) == 0)
            v = ring_mem[(rd_ptr + $urandom_range(0, ring_fill - 1)) % RING_DEPTH];
         pick = $urandom_range(0, 9);
         if (pick < 2) ec = 10'($urandom);
         else if (pick < 3) ec = 10'($urandom_range(0, ring_fill));
         else ec = 10'($urandom_range(0, (ring_fill < 20) ? ring_fill : 20));
         send_request(k, v, 9'($urandom), ec, 1'($urandom));
      end
      no_idle = 1'b0;
   endtask

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      wr_ptr = 0;
      rd_ptr = 0;
      ring_fill = 0;
      ring_clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_basic_ops();
      test_wrap_around();
      test_random_mix(700);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ring_replies_due.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);

      $display("Sent %0d requests over every operation code, empty and full rings,",
               requests_sent);
      $display("overwrite on a full ring and both flush modes; %0d responses checked.",
               replies_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/orbb_pkg.sv
design/orbb_ctrl.sv
design/orbb_dpath.sv
design/overwriting_byte_ring_buffer.sv
dv/overwriting_byte_ring_buffer_tb.sv
